[sv/kvl_pkg.sv]
// shared types and constants of the key/value text lookup unit
package kvl_pkg;

  // character codes
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7A;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpZ    = 8'h5A;

  // status codes
  localparam logic [2:0] StNotFound  = 3'd0;
  localparam logic [2:0] StFound     = 3'd1;
  localparam logic [2:0] StNoEquals  = 3'd2;
  localparam logic [2:0] StNoValue   = 3'd3;
  localparam logic [2:0] StOpenQuote = 3'd4;

  // value modes
  localparam logic [1:0] ModeInt   = 2'd0;
  localparam logic [1:0] ModeWord  = 2'd1;
  localparam logic [1:0] ModeQuote = 2'd2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegKeyChars  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyLength = 2'd1;
  localparam logic [CfgIdxW-1:0] RegValueMode = 2'd2;

  // depth of the queue between classifier and engine
  localparam int unsigned FifoDepth = 2;

  // match position saturates here
  localparam logic [3:0] MatchPosMax = 4'd15;

  // search phase of the engine
  typedef enum logic [4:0] {
    PhSeek      = 5'b00001,
    PhWantEq    = 5'b00010,
    PhWantValue = 5'b00100,
    PhInValue   = 5'b01000,
    PhInQuote   = 5'b10000
  } phase_e;

  // classified character
  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
    logic       is_space;
    logic       is_word;
    logic       is_digit;
    logic       is_symbol;
    logic       is_quote;
    logic       is_nul;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic [63:0] key_chars;
    logic [3:0]  key_length;
    logic [1:0]  value_mode;
  } cfg_t;

endpackage

[sv/kvl_ifs.sv]
// channel interfaces: text input, configuration writes, lookup results
interface kvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface kvl_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kvl_pkg::CfgIdxW-1:0] index;
  logic [63:0]                data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface kvl_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [31:0] number_value;
  logic [7:0]        value_char;
  logic              char_valid;
  logic              run_last;

  modport source (output valid, output status, output number_value, output value_char,
                  output char_valid, output run_last, input ready);
  modport sink (input valid, input status, input number_value, input value_char,
                input char_valid, input run_last, output ready);
endinterface

[sv/key_value_text_lookup_unit.sv]
// top level of the key/value text lookup unit
//
//   channel   dir  transaction carries
//   in_i      in   text_char, end_of_text
//   cfg_i     in   index (key_chars, key_length, value_mode), data
//   out_o     out  status, number_value, value_char, char_valid, run_last
//
// One character per cycle sustained unless an unread result stalls the engine.
// The engine step sets the rate; a character is queued, then its result registered.
// Reset clears the lookup state and sets the key to empty, length 1, integer mode.
// A two-entry queue sits between classifier and engine; the engine stalls only
// while an unread result holds the output register.
module key_value_text_lookup_unit #(
  parameter int unsigned MaxKeyChars = 8,
  parameter int unsigned NumberWidth = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kvl_in_if.sink     in_i,
  kvl_cfg_if.sink    cfg_i,
  kvl_out_if.source  out_o
);

  kvl_pkg::cfg_t  cfg_q;
  kvl_pkg::item_t fr_item;
  kvl_pkg::item_t q_item;
  logic           fr_push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_chars  <= '0;
      cfg_q.key_length <= 4'd1;
      cfg_q.value_mode <= kvl_pkg::ModeInt;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        kvl_pkg::RegKeyChars:  cfg_q.key_chars  <= cfg_i.data;
        kvl_pkg::RegKeyLength: cfg_q.key_length <= cfg_i.data[3:0];
        kvl_pkg::RegValueMode: cfg_q.value_mode <= cfg_i.data[1:0];
        default: begin
        end
      endcase
    end
  end

  // classifier
  kvl_front u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (fr_push),
    .item_o (fr_item)
  );

  // queue
  kvl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // engine
  kvl_back #(
    .MaxKeyChars (MaxKeyChars),
    .NumberWidth (NumberWidth)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .item_i  (q_item),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

[sv/kvl_front.sv]
// front end: accepts text characters and classifies them for the engine
module kvl_front (
  kvl_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output kvl_pkg::item_t  item_o
);

  logic [7:0] c;

  assign c = in_i.text_char;

  // accept whenever the queue has room
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // character classes
  always_comb begin
    item_o             = '0;
    item_o.text_char   = c;
    item_o.end_of_text = in_i.end_of_text;
    item_o.is_space    = (c == kvl_pkg::CharSpace) ||
                         (c inside {[kvl_pkg::CharTab:kvl_pkg::CharCr]});
    item_o.is_digit    = c inside {[kvl_pkg::CharZero:kvl_pkg::CharNine]};
    item_o.is_word     = c inside {[kvl_pkg::CharLowA:kvl_pkg::CharLowZ],
                                   [kvl_pkg::CharUpA:kvl_pkg::CharUpZ],
                                   [kvl_pkg::CharZero:kvl_pkg::CharNine],
                                   kvl_pkg::CharDash};
    item_o.is_symbol   = c inside {kvl_pkg::CharEq, kvl_pkg::CharLParen,
                                   kvl_pkg::CharRParen, kvl_pkg::CharComma};
    item_o.is_quote    = (c == kvl_pkg::CharQuote);
    item_o.is_nul      = (c == kvl_pkg::CharNul);
  end

endmodule

[sv/kvl_fifo.sv]
// short queue of classified characters between front end and engine
module kvl_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kvl_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output kvl_pkg::item_t item_o
);

  localparam int unsigned PtrW = (kvl_pkg::FifoDepth > 1) ? $clog2(kvl_pkg::FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(kvl_pkg::FifoDepth + 1);

  kvl_pkg::item_t  mem_q [kvl_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(kvl_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(kvl_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(kvl_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[sv/kvl_back.sv]
// engine: token state machine, key match, value parse and result register
module kvl_back #(
  parameter int unsigned MaxKeyChars = 8,
  parameter int unsigned NumberWidth = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kvl_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  kvl_pkg::item_t item_i,
  output logic           pop_o,
  kvl_out_if.source      out_o
);

  typedef struct packed {
    kvl_pkg::phase_e        phase;
    logic                   tok_word;
    logic [3:0]             mpos;
    logic                   mok;
    logic [NumberWidth-1:0] acc;
    logic                   neg;
    logic                   dig_end;
    logic                   done;
    logic                   hr;
    logic [2:0]             st;
    logic [31:0]            num;
    logic [7:0]             ch;
    logic                   cv;
    logic                   last;
  } eng_t;

  // lookup state after reset: seeking the key, match still possible
  localparam eng_t EngReset = '{phase: kvl_pkg::PhSeek, mok: 1'b1, default: '0};

  eng_t       eng_q, eng_d;
  logic       out_valid_q, out_valid_d;
  logic       fire;
  logic [3:0] klen;
  logic       mode_int;
  logic       mode_quote;

  // effective key length and mode
  always_comb begin
    klen = cfg_i.key_length;
    if (klen == 4'd0) begin
      klen = 4'd1;
    end else if (klen > 4'(MaxKeyChars)) begin
      klen = 4'(MaxKeyChars);
    end
  end

  assign mode_int   = !(cfg_i.value_mode inside {kvl_pkg::ModeWord, kvl_pkg::ModeQuote});
  assign mode_quote = (cfg_i.value_mode == kvl_pkg::ModeQuote);

  function automatic eng_t f_emit(eng_t s, logic [2:0] st, logic [31:0] num,
                                  logic [7:0] ch, logic cv, logic last);
    eng_t r;
    r      = s;
    r.hr   = 1'b1;
    r.st   = st;
    r.num  = num;
    r.ch   = ch;
    r.cv   = cv;
    r.last = last;
    if (last) begin
      r.done = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] f_key_byte(logic [63:0] key, logic [3:0] p);
    return key[8*p[2:0] +: 8];
  endfunction

  // add one character to the current word
  function automatic eng_t f_extend(eng_t s, kvl_pkg::item_t it, logic [3:0] kl,
                                    logic [63:0] key, logic m_int);
    eng_t                   r;
    logic [NumberWidth-1:0] limit;
    logic [NumberWidth+3:0] prod;
    logic [3:0]             d;
    r     = s;
    limit = {1'b1, {(NumberWidth-1){1'b0}}} - NumberWidth'(!s.neg);
    d     = 4'(it.text_char - kvl_pkg::CharZero);
    prod  = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (NumberWidth+4)'(d);
    if (s.phase == kvl_pkg::PhSeek) begin
      if (!(s.mpos < kl && it.text_char == f_key_byte(key, s.mpos))) begin
        r.mok = 1'b0;
      end
    end else if (m_int) begin
      if (s.mpos == 4'd0 && it.text_char == kvl_pkg::CharDash) begin
        r.neg = 1'b1;
      end else if (!s.dig_end && it.is_digit) begin
        if (prod > (NumberWidth+4)'(limit)) begin
          r.acc = limit;
        end else begin
          r.acc = prod[NumberWidth-1:0];
        end
      end else begin
        r.dig_end = 1'b1;
      end
    end else begin
      r = f_emit(r, kvl_pkg::StFound, '0, it.text_char, 1'b1, 1'b0);
    end
    if (s.mpos < kvl_pkg::MatchPosMax) begin
      r.mpos = s.mpos + 4'd1;
    end
    return r;
  endfunction

  // end of the current word
  function automatic eng_t f_close(eng_t s, logic [3:0] kl, logic m_int);
    eng_t                   r;
    logic [NumberWidth-1:0] sv;
    r          = s;
    r.tok_word = 1'b0;
    sv         = s.neg ? (~s.acc + 1'b1) : s.acc;
    if (s.phase == kvl_pkg::PhSeek) begin
      if (s.mok && s.mpos == kl) begin
        r.phase = kvl_pkg::PhWantEq;
      end
    end else if (m_int) begin
      r = f_emit(r, kvl_pkg::StFound, 32'($signed(sv)), 8'd0, 1'b0, 1'b1);
    end else if (s.hr) begin
      r.last = 1'b1;
      r.done = 1'b1;
    end else begin
      r = f_emit(r, kvl_pkg::StFound, '0, 8'd0, 1'b0, 1'b1);
    end
    return r;
  endfunction

  // first character of a new token
  function automatic eng_t f_start(eng_t s, kvl_pkg::item_t it, logic [3:0] kl,
                                   logic [63:0] key, logic m_int, logic m_quote);
    eng_t r;
    r = s;
    if (it.is_space || it.is_nul) begin
      return r;
    end
    if (s.phase == kvl_pkg::PhWantValue && m_quote) begin
      if (it.is_quote) begin
        r.phase = kvl_pkg::PhInQuote;
      end else begin
        r = f_emit(r, kvl_pkg::StNoValue, '0, 8'd0, 1'b0, 1'b1);
      end
      return r;
    end
    if (it.is_word) begin
      if (s.phase == kvl_pkg::PhWantEq) begin
        return f_emit(r, kvl_pkg::StNoEquals, '0, 8'd0, 1'b0, 1'b1);
      end
      if (s.phase == kvl_pkg::PhWantValue) begin
        r.phase = kvl_pkg::PhInValue;
      end
      r.tok_word = 1'b1;
      r.mpos     = 4'd0;
      r.mok      = 1'b1;
      r.acc      = '0;
      r.neg      = 1'b0;
      r.dig_end  = 1'b0;
      return f_extend(r, it, kl, key, m_int);
    end
    if (s.phase == kvl_pkg::PhSeek) begin
      if (it.is_symbol && kl == 4'd1 && it.text_char == f_key_byte(key, 4'd0)) begin
        r.phase = kvl_pkg::PhWantEq;
      end
    end else if (s.phase == kvl_pkg::PhWantEq) begin
      if (it.text_char == kvl_pkg::CharEq) begin
        r.phase = kvl_pkg::PhWantValue;
      end else begin
        r = f_emit(r, kvl_pkg::StNoEquals, '0, 8'd0, 1'b0, 1'b1);
      end
    end else if (m_int) begin
      r = f_emit(r, kvl_pkg::StFound, '0, 8'd0, 1'b0, 1'b1);
    end else begin
      r = f_emit(r, kvl_pkg::StFound, '0, it.text_char, 1'b1, 1'b1);
    end
    return r;
  endfunction

  // one character step
  always_comb begin
    logic term;
    eng_d      = eng_q;
    eng_d.hr   = 1'b0;
    eng_d.st   = kvl_pkg::StNotFound;
    eng_d.num  = '0;
    eng_d.ch   = 8'd0;
    eng_d.cv   = 1'b0;
    eng_d.last = 1'b0;
    term       = item_i.end_of_text || item_i.is_nul;

    if (!eng_d.done) begin
      if (eng_d.phase == kvl_pkg::PhInQuote) begin
        if (item_i.is_quote) begin
          eng_d = f_emit(eng_d, kvl_pkg::StFound, '0, 8'd0, 1'b0, 1'b1);
        end else if (term) begin
          eng_d = f_emit(eng_d, kvl_pkg::StOpenQuote, '0, 8'd0, 1'b0, 1'b1);
        end else begin
          eng_d = f_emit(eng_d, kvl_pkg::StFound, '0, item_i.text_char, 1'b1, 1'b0);
        end
      end else begin
        if (eng_d.tok_word) begin
          if (item_i.is_word) begin
            eng_d = f_extend(eng_d, item_i, klen, cfg_i.key_chars, mode_int);
          end else begin
            eng_d = f_close(eng_d, klen, mode_int);
          end
          if (!eng_d.done && !item_i.is_word) begin
            eng_d = f_start(eng_d, item_i, klen, cfg_i.key_chars, mode_int, mode_quote);
          end
        end else begin
          eng_d = f_start(eng_d, item_i, klen, cfg_i.key_chars, mode_int, mode_quote);
        end
        // text ends: conclude with a status
        if (term && !eng_d.done) begin
          if (eng_d.tok_word) begin
            eng_d = f_close(eng_d, klen, mode_int);
          end
          if (!eng_d.done) begin
            case (eng_d.phase)
              kvl_pkg::PhSeek: begin
                eng_d = f_emit(eng_d, kvl_pkg::StNotFound, '0, 8'd0, 1'b0, 1'b1);
              end
              kvl_pkg::PhWantEq: begin
                eng_d = f_emit(eng_d, kvl_pkg::StNoEquals, '0, 8'd0, 1'b0, 1'b1);
              end
              kvl_pkg::PhInQuote: begin
                eng_d = f_emit(eng_d, kvl_pkg::StOpenQuote, '0, 8'd0, 1'b0, 1'b1);
              end
              default: begin
                eng_d = f_emit(eng_d, kvl_pkg::StNoValue, '0, 8'd0, 1'b0, 1'b1);
              end
            endcase
          end
        end
      end
    end

    // end of text clears the lookup
    if (item_i.end_of_text) begin
      eng_d.phase    = kvl_pkg::PhSeek;
      eng_d.tok_word = 1'b0;
      eng_d.mpos     = 4'd0;
      eng_d.mok      = 1'b1;
      eng_d.acc      = '0;
      eng_d.neg      = 1'b0;
      eng_d.dig_end  = 1'b0;
      eng_d.done     = 1'b0;
    end
  end

  // take a character when the result register is free or being drained
  assign fire        = valid_i && (!out_valid_q || out_o.ready);
  assign pop_o       = fire;
  assign out_valid_d = fire ? eng_d.hr : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_q       <= EngReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        eng_q <= eng_d;
      end
    end
  end

  // result fields come straight from the step register
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = eng_q.st;
  assign out_o.number_value = $signed(eng_q.num);
  assign out_o.value_char   = eng_q.ch;
  assign out_o.char_valid   = eng_q.cv;
  assign out_o.run_last     = eng_q.last;

endmodule

[verif/kvl_lookup_checker.sv]
// checker for the key/value text lookup unit: predicts lookup results and compares them
`timescale 1ns / 1ps
module kvl_lookup_checker
  import kvl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  kvl_in_if    in_mon,
  kvl_cfg_if   cfg_mon,
  kvl_out_if   out_mon,
  output int   mismatch_count_o,
  output int   pending_count_o
);

  localparam int unsigned KeyCharsMax = 8;
  localparam int unsigned NumWidth    = 32;
  // the unused mode code behaves like integer mode
  localparam logic [1:0]  ModeSpare   = 2'd3;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] number_value;
    logic [7:0]         value_char;
    logic               char_valid;
    logic               run_last;
  } lookup_res_t;

  // register copies
  logic [63:0] key_reg;
  logic [3:0]  key_len_reg;
  logic [1:0]  mode_reg;

  // scanner state
  phase_e      scan_phase;
  logic        in_word;
  logic [3:0]  match_pos;
  logic        match_ok;
  logic [63:0] num_acc;
  logic        num_neg;
  logic        digits_done;
  logic        lookup_over;

  // result of the current character, if any
  logic        res_have;
  lookup_res_t res_now;

  lookup_res_t lookup_results_q[$];

  function automatic int unsigned key_len_eff();
    if (key_len_reg == 4'd0) return 1;
    if (key_len_reg > KeyCharsMax) return KeyCharsMax;
    return key_len_reg;
  endfunction

  function automatic logic [7:0] key_byte(input logic [3:0] p);
    return key_reg[8*p[2:0] +: 8];
  endfunction

  function automatic logic [1:0] mode_eff();
    return (mode_reg == ModeSpare) ? ModeInt : mode_reg;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CharSpace || (c >= CharTab && c <= CharCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CharZero && c <= CharNine;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= CharLowA && c <= CharLowZ) || (c >= CharUpA && c <= CharUpZ) ||
           is_digit(c) || c == CharDash;
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == CharEq || c == CharLParen || c == CharRParen || c == CharComma;
  endfunction

  task automatic clear_lookup();
    scan_phase  = PhSeek;
    in_word     = 1'b0;
    match_pos   = '0;
    match_ok    = 1'b1;
    num_acc     = '0;
    num_neg     = 1'b0;
    digits_done = 1'b0;
    lookup_over = 1'b0;
  endtask

  task automatic give(input logic [2:0] st, input logic [31:0] num, input logic [7:0] ch,
                      input logic cv, input logic last);
    res_have             = 1'b1;
    res_now.status       = st;
    res_now.number_value = num;
    res_now.value_char   = ch;
    res_now.char_valid   = cv;
    res_now.run_last     = last;
    if (last) lookup_over = 1'b1;
  endtask

  // one more character of a word token
  task automatic extend_word(input logic [7:0] c);
    logic [63:0] limit;
    logic [63:0] digit;
    if (scan_phase == PhSeek) begin
      if (!(match_pos < key_len_eff() && c == key_byte(match_pos))) match_ok = 1'b0;
    end else if (mode_eff() == ModeInt) begin
      limit = (64'd1 << (NumWidth - 1)) - (num_neg ? 64'd0 : 64'd1);
      if (match_pos == 4'd0 && c == CharDash) begin
        num_neg = 1'b1;
      end else if (!digits_done && is_digit(c)) begin
        digit = 64'(c - CharZero);
        if (num_acc > (limit - digit) / 10) num_acc = limit;
        else num_acc = num_acc * 10 + digit;
      end else begin
        digits_done = 1'b1;
      end
    end else begin
      give(StFound, '0, c, 1'b1, 1'b0);
    end
    if (match_pos < MatchPosMax) match_pos++;
  endtask

  // a word token ends
  task automatic close_word();
    logic [63:0] signed_acc;
    in_word = 1'b0;
    if (scan_phase == PhSeek) begin
      if (match_ok && match_pos == key_len_eff()) scan_phase = PhWantEq;
    end else if (mode_eff() == ModeInt) begin
      signed_acc = num_neg ? (64'd0 - num_acc) : num_acc;
      give(StFound, signed_acc[31:0], '0, 1'b0, 1'b1);
    end else if (res_have) begin
      res_now.run_last = 1'b1;
      lookup_over      = 1'b1;
    end else begin
      give(StFound, '0, '0, 1'b0, 1'b1);
    end
  endtask

  // first character of a new token
  task automatic start_token(input logic [7:0] c);
    if (is_space(c) || c == CharNul) return;
    if (scan_phase == PhWantValue && mode_eff() == ModeQuote) begin
      if (c == CharQuote) scan_phase = PhInQuote;
      else give(StNoValue, '0, '0, 1'b0, 1'b1);
      return;
    end
    if (is_word(c)) begin
      if (scan_phase == PhWantEq) begin
        give(StNoEquals, '0, '0, 1'b0, 1'b1);
        return;
      end
      if (scan_phase == PhWantValue) scan_phase = PhInValue;
      in_word     = 1'b1;
      match_pos   = '0;
      match_ok    = 1'b1;
      num_acc     = '0;
      num_neg     = 1'b0;
      digits_done = 1'b0;
      extend_word(c);
      return;
    end
    if (scan_phase == PhSeek) begin
      if (is_symbol(c) && key_len_eff() == 1 && c == key_byte(4'd0)) scan_phase = PhWantEq;
    end else if (scan_phase == PhWantEq) begin
      if (c == CharEq) scan_phase = PhWantValue;
      else give(StNoEquals, '0, '0, 1'b0, 1'b1);
    end else if (mode_eff() == ModeInt) begin
      give(StFound, '0, '0, 1'b0, 1'b1);
    end else begin
      give(StFound, '0, c, 1'b1, 1'b1);
    end
  endtask

  // advance the lookup by one text character
  task automatic scan_char(input logic [7:0] c, input logic eot);
    logic term;
    term     = eot || c == CharNul;
    res_have = 1'b0;
    if (!lookup_over) begin
      if (scan_phase == PhInQuote) begin
        if (c == CharQuote) give(StFound, '0, '0, 1'b0, 1'b1);
        else if (term) give(StOpenQuote, '0, '0, 1'b0, 1'b1);
        else give(StFound, '0, c, 1'b1, 1'b0);
      end else begin
        if (in_word) begin
          if (is_word(c)) extend_word(c);
          else close_word();
          if (!lookup_over && !is_word(c)) start_token(c);
        end else begin
          start_token(c);
        end
        // text ends here: conclude with the status of the phase reached
        if (term && !lookup_over) begin
          if (in_word) close_word();
          if (!lookup_over) begin
            case (scan_phase)
              PhSeek:    give(StNotFound, '0, '0, 1'b0, 1'b1);
              PhWantEq:  give(StNoEquals, '0, '0, 1'b0, 1'b1);
              PhInQuote: give(StOpenQuote, '0, '0, 1'b0, 1'b1);
              default:   give(StNoValue, '0, '0, 1'b0, 1'b1);
            endcase
          end
        end
      end
    end
    if (eot) clear_lookup();
  endtask

  task automatic flag_error(input string why, input logic has_want, input lookup_res_t got,
                            input lookup_res_t want);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t: %s", $time, why);
      if (has_want)
        $display("  expected status %0d number %0d char %02h char_valid %0b run_last %0b",
                 want.status, want.number_value, want.value_char, want.char_valid,
                 want.run_last);
      $display("  actual   status %0d number %0d char %02h char_valid %0b run_last %0b",
               got.status, got.number_value, got.value_char, got.char_valid, got.run_last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t got;
    lookup_res_t want;
    if (!rst_ni) begin
      key_reg     = '0;
      key_len_reg = 4'd1;
      mode_reg    = ModeInt;
      clear_lookup();
      lookup_results_q.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      // result transaction against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.status       = out_mon.status;
        got.number_value = out_mon.number_value;
        got.value_char   = out_mon.value_char;
        got.char_valid   = out_mon.char_valid;
        got.run_last     = out_mon.run_last;
        if (lookup_results_q.size() == 0) begin
          flag_error("result with none expected", 1'b0, got, got);
        end else begin
          want = lookup_results_q.pop_front();
          if (got.status !== want.status || got.number_value !== want.number_value ||
              got.value_char !== want.value_char || got.char_valid !== want.char_valid ||
              got.run_last !== want.run_last)
            flag_error("result mismatch", 1'b1, got, want);
        end
      end
      // text transaction uses the registers as they were before this edge
      if (in_mon.valid && in_mon.ready) begin
        scan_char(in_mon.text_char, in_mon.end_of_text);
        if (res_have) lookup_results_q.push_back(res_now);
      end
      // register write transaction
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          RegKeyChars:  key_reg = cfg_mon.data;
          RegKeyLength: key_len_reg = cfg_mon.data[3:0];
          RegValueMode: mode_reg = cfg_mon.data[1:0];
          default: ;
        endcase
      end
      pending_count_o = lookup_results_q.size();
    end
  end

endmodule

[verif/tb_key_value_text_lookup_unit.sv]
// testbench top for the key/value text lookup unit: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_key_value_text_lookup_unit;
  import kvl_pkg::*;

  localparam int unsigned TextTarget    = 1300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned SettleCycles  = 8;
  // index beyond the register list, writes to it are dropped
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  kvl_in_if  text_ch ();
  kvl_cfg_if cfg_ch ();
  kvl_out_if res_ch ();

  int          mismatches;
  int          pending;
  int unsigned chars_sent = 0;
  bit          no_idle = 1'b0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int unsigned idle_cycles = 0;

  // text under construction, key bytes as they appear in text, mode in force
  logic [7:0] doc_q[$];
  logic [7:0] key_text_q[$];
  logic [1:0] mode_now = ModeInt;

  key_value_text_lookup_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (text_ch),
    .cfg_i  (cfg_ch),
    .out_o  (res_ch)
  );

  kvl_lookup_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_mon           (text_ch),
    .cfg_mon          (cfg_ch),
    .out_mon          (res_ch),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || (text_ch.valid && text_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 15);
  endfunction

  // result side: random stalls, plus a long hold-off when asked
  initial begin
    int unsigned n;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_done != hold_asked) begin
        res_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_done++;
      end else begin
        n = draw_wait();
        if (n > 0) begin
          res_ch.ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] word_char();
    int unsigned r;
    r = $urandom_range(0, 62);
    if (r < 26) return CharLowA + 8'(r);
    if (r < 52) return CharUpA + 8'(r - 26);
    if (r < 62) return CharZero + 8'(r - 52);
    return CharDash;
  endfunction

  function automatic logic [7:0] symbol_char();
    case ($urandom_range(0, 3))
      0:       return CharEq;
      1:       return CharLParen;
      2:       return CharRParen;
      default: return CharComma;
    endcase
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CharQuote);
    return c;
  endfunction

  task automatic put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
  endtask

  task automatic put_space(input int unsigned min_n);
    int unsigned n;
    int unsigned r;
    n = $urandom_range(min_n, min_n + 2);
    repeat (n) begin
      r = $urandom_range(0, 6);
      doc_q.push_back(r < 5 ? CharTab + 8'(r) : CharSpace);
    end
  endtask

  task automatic put_word(input int unsigned max_len);
    repeat ($urandom_range(1, max_len)) doc_q.push_back(word_char());
  endtask

  // a token that is not the key, then separation
  task automatic put_filler();
    case ($urandom_range(0, 3))
      0, 1: begin
        put_word(6);
        put_space(1);
      end
      2: begin
        doc_q.push_back(symbol_char());
        put_space(0);
      end
      default: begin
        doc_q.push_back(8'($urandom_range(1, 255)));
        put_space(1);
      end
    endcase
  endtask

  // value token for the mode in force
  task automatic put_value();
    longint edge_vals[4];
    int unsigned n;
    edge_vals = '{64'sd2147483647, 64'sd2147483648, -64'sd2147483648, -64'sd2147483649};
    case (mode_now)
      ModeWord: begin
        if ($urandom_range(0, 5) == 0) doc_q.push_back(symbol_char());
        else put_word(6);
      end
      ModeQuote: begin
        if ($urandom_range(0, 7) == 0) begin
          put_word(3);
        end else begin
          doc_q.push_back(CharQuote);
          repeat ($urandom_range(0, 6)) doc_q.push_back(quoted_char());
          if ($urandom_range(0, 5) != 0) doc_q.push_back(CharQuote);
        end
      end
      default: begin
        case ($urandom_range(0, 7))
          0: put_str($sformatf("%0d", edge_vals[$urandom_range(0, 3)]));
          1: doc_q.push_back($urandom_range(0, 1) ? symbol_char() : 8'($urandom_range(1, 255)));
          default: begin
            n = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) begin
              doc_q.push_back(CharDash);
              n = $urandom_range(0, 12);
            end
            repeat (n) doc_q.push_back(CharZero + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3))
              doc_q.push_back(word_char());
          end
        endcase
      end
    endcase
  endtask

  // one text: mostly key = value with random content, some broken or pure noise
  task automatic build_doc();
    int unsigned shape;
    doc_q.delete();
    shape = $urandom_range(0, 11);
    repeat ($urandom_range(0, 3)) put_filler();
    if (shape == 11) begin
      repeat ($urandom_range(1, 8)) doc_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    foreach (key_text_q[i]) doc_q.push_back(key_text_q[i]);
    case (shape)
      10: begin
        put_space(1);
        if ($urandom_range(0, 1)) put_word(4);
        else doc_q.push_back(symbol_char());
      end
      9: begin
        put_space(0);
        doc_q.push_back(CharEq);
        put_space(0);
      end
      default: begin
        put_space(0);
        doc_q.push_back(CharEq);
        put_space(0);
        put_value();
        if ($urandom_range(0, 1)) begin
          put_space(1);
          repeat ($urandom_range(0, 2)) put_filler();
        end
      end
    endcase
  endtask

  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned n;
    n = draw_wait();
    if (n > 0) begin
      text_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_char   <= c;
    text_ch.end_of_text <= last;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_doc();
    int i;
    for (i = 0; i < doc_q.size(); i++) send_char(doc_q[i], i == doc_q.size() - 1);
  endtask

  // stop offering text and wait until every predicted result is out
  task automatic wait_drained();
    text_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // back-to-back register write transactions, optionally one to the unused index
  task automatic set_config(input logic [63:0] key, input logic [3:0] len,
                            input logic [1:0] mode, input bit spare);
    logic [CfgIdxW-1:0] idx[4];
    logic [63:0]        val[4];
    int                 i;
    idx[0] = RegKeyChars;
    val[0] = key;
    idx[1] = RegKeyLength;
    val[1] = {$urandom(), 28'($urandom()), len};
    idx[2] = RegValueMode;
    val[2] = {$urandom(), 30'($urandom()), mode};
    idx[3] = RegUnused;
    val[3] = {$urandom(), $urandom()};
    for (i = 0; i < (spare ? 4 : 3); i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // random setting per phase, with the extremes forced on some phases
  task automatic pick_config(input int unsigned ph);
    logic [63:0] key;
    logic [3:0]  len_reg;
    logic [1:0]  mode;
    int unsigned eff;
    int          i;
    key  = {$urandom(), $urandom()};
    eff  = (ph == 0) ? 8 : $urandom_range(1, 8);
    mode = 2'($urandom_range(0, 3));
    for (i = 0; i < eff; i++) key[8*i +: 8] = word_char();
    if ($urandom_range(0, 7) == 0) begin
      eff       = 1;
      key[7:0]  = symbol_char();
    end
    len_reg = 4'(eff);
    if (eff == 8 && $urandom_range(0, 2) == 0) len_reg = 4'($urandom_range(9, 15));
    if (eff == 1 && $urandom_range(0, 2) == 0) len_reg = '0;
    if (ph == 3) begin
      key     = '1;
      len_reg = '1;
      eff     = 8;
    end
    if (ph == 2) mode = ModeWord;
    key_text_q.delete();
    for (i = 0; i < eff; i++) key_text_q.push_back(key[8*i +: 8]);
    mode_now = mode;
    set_config(key, len_reg, mode, 1'b0);
  endtask

  // directed text with a one-character key
  task automatic directed_doc(input logic [7:0] key_ch, input logic [3:0] len,
                              input logic [1:0] mode, input string s, input bit spare);
    logic [63:0] key;
    key      = {$urandom(), $urandom()};
    key[7:0] = key_ch;
    wait_drained();
    set_config(key, len, mode, spare);
    doc_q.delete();
    put_str(s);
    send_doc();
  endtask

  initial begin
    int unsigned goal;
    int unsigned budget;
    int unsigned ph;
    text_ch.valid       = 1'b0;
    text_ch.text_char   = '0;
    text_ch.end_of_text = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = RegKeyChars;
    cfg_ch.data         = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: a lone high character ends the text, nothing found
    doc_q.delete();
    doc_q.push_back(8'hFF);
    send_doc();
    // saturating negative integer, text ends on a digit
    directed_doc("k", 4'd1, ModeInt, "k=-9999999999", 1'b1);
    // nul ends the content, later characters ignored up to end of text
    doc_q.delete();
    doc_q.push_back(CharNul);
    doc_q.push_back("x");
    send_doc();
    // key length zero acts as one, quote left open at the end
    directed_doc("k", 4'd0, ModeQuote, "k=\"a", 1'b0);
    // symbol key with a symbol as word value
    directed_doc(CharComma, 4'd1, ModeWord, ",=,", 1'b0);

    // random phases of well-formed, broken and noise texts
    goal = chars_sent + TextTarget;
    ph   = 0;
    while (chars_sent < goal) begin
      wait_drained();
      pick_config(ph);
      no_idle = ($urandom_range(0, 3) == 0);
      if (ph == 2) hold_asked++;
      budget = chars_sent + $urandom_range(60, 180);
      while (chars_sent < budget) begin
        build_doc();
        send_doc();
        if (ph == 1 || $urandom_range(0, 24) == 0) wait_drained();
      end
      ph++;
    end
    no_idle = 1'b0;
    wait_drained();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
sv/kvl_pkg.sv
sv/kvl_ifs.sv
sv/kvl_front.sv
sv/kvl_fifo.sv
sv/kvl_back.sv
sv/key_value_text_lookup_unit.sv
verif/kvl_lookup_checker.sv
verif/tb_key_value_text_lookup_unit.sv
